// ===== rtl/core/skl_pkg.sv =====
// Shared types for the sorted key list: controller states, status codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
package skl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_INS,
    ST_SHIFT_ERA,
    ST_PLACE,
    ST_SHRINK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RA_HOLD,
    RA_ZERO,
    RA_TOP,
    RA_ABOVE_RD,
    RA_INC,
    RA_DEC
  } ra_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_NEW
  } wr_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_issue;
    ra_op_t  ra_op;
    logic    pos_from_rd;
    logic    pos_from_fill;
    wr_op_t  wr_op;
    logic    fill_inc;
    logic    fill_dec;
    logic    status_we;
    status_t status_code;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic is_erase;
    logic rd_valid;
    logic rd_match;
    logic rd_at_top;
    logic rd_at_pos;
    logic ra_lt_fill;
    logic ra_ge_pos;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/core/skl_ctrl.sv =====
// Controller for the sorted key list: sequences scan, shift and place
// phases of one item. Depends on skl_pkg.
module skl_ctrl import skl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     req_type,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.ra_op       = RA_HOLD;
    cmd.wr_op       = WR_NONE;
    cmd.status_code = STAT_OK;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load      = 1'b1;
          cmd.status_we = 1'b1;
          if (req_type) begin
            if (stat.empty) begin
              cmd.status_code = STAT_NOT_FOUND;
              state_next      = ST_DONE;
            end else begin
              cmd.ra_op  = RA_ZERO;
              state_next = ST_SCAN;
            end
          end else if (stat.full) begin
            cmd.status_code = STAT_FULL;
            state_next      = ST_DONE;
          end else if (stat.empty) begin
            cmd.pos_from_fill = 1'b1;
            state_next        = ST_PLACE;
          end else begin
            cmd.ra_op  = RA_ZERO;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // stop issuing once a hit shows so no stale read is left in flight
        cmd.rd_issue = stat.ra_lt_fill && !(stat.rd_valid && stat.rd_match);
        if (cmd.rd_issue) begin
          cmd.ra_op = RA_INC;
        end
        if (stat.rd_valid) begin
          if (stat.rd_match) begin
            cmd.pos_from_rd = 1'b1;
            if (stat.is_erase) begin
              if (stat.rd_at_top) begin
                state_next = ST_SHRINK;
              end else begin
                cmd.ra_op  = RA_ABOVE_RD;
                state_next = ST_SHIFT_ERA;
              end
            end else begin
              cmd.ra_op  = RA_TOP;
              state_next = ST_SHIFT_INS;
            end
          end else if (stat.rd_at_top) begin
            if (stat.is_erase) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = STAT_NOT_FOUND;
              state_next      = ST_DONE;
            end else begin
              cmd.pos_from_fill = 1'b1;
              state_next        = ST_PLACE;
            end
          end
        end
      end
      ST_SHIFT_INS: begin
        // move entries from the top down to the insert slot, one place up
        cmd.rd_issue = stat.ra_ge_pos && stat.ra_lt_fill;
        if (cmd.rd_issue) begin
          cmd.ra_op = RA_DEC;
        end
        if (stat.rd_valid) begin
          cmd.wr_op = WR_UP;
          if (stat.rd_at_pos) begin
            state_next = ST_PLACE;
          end
        end
      end
      ST_SHIFT_ERA: begin
        // close the gap: move entries above the erased slot one place down
        cmd.rd_issue = stat.ra_lt_fill;
        if (cmd.rd_issue) begin
          cmd.ra_op = RA_INC;
        end
        if (stat.rd_valid) begin
          cmd.wr_op = WR_DOWN;
          if (stat.rd_at_top) begin
            state_next = ST_SHRINK;
          end
        end
      end
      ST_PLACE: begin
        cmd.wr_op    = WR_NEW;
        cmd.fill_inc = 1'b1;
        state_next   = ST_DONE;
      end
      ST_SHRINK: begin
        cmd.fill_dec = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/skl_dpath.sv =====
// Datapath for the sorted key list: entry memory, request registers,
// address counters, fill count, head id and the result register.
// Depends on skl_pkg.
module skl_dpath import skl_pkg::*; #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int ID_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        req_type,
  input  logic [15:0] item_id,
  input  logic [15:0] item_width,
  input  logic [15:0] item_height,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] smallest_id,
  output logic        smallest_valid,
  output logic [6:0]  entry_count,
  output logic [1:0]  status
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = KEY_BITS + ID_BITS;

  logic [ENT_W-1:0]    mem [DEPTH];
  logic [ENT_W-1:0]    rdata;
  logic                rd_valid;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    ra;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    fill;
  logic                key_select;
  logic                req_erase;
  logic [KEY_BITS-1:0] req_key;
  logic [ID_BITS-1:0]  req_id;
  logic [ID_BITS-1:0]  head_id;
  status_t             status_reg;

  logic                wr_en;
  logic [CNT_W-1:0]    wr_addr;
  logic [ENT_W-1:0]    wr_data;
  logic [KEY_BITS-1:0] rd_key;
  logic [ID_BITS-1:0]  rd_id;
  logic [CNT_W-1:0]    fill_top;

  assign rd_key   = rdata[ENT_W-1:ID_BITS];
  assign rd_id    = rdata[ID_BITS-1:0];
  assign fill_top = fill - CNT_W'(1);

  always_comb begin
    stat.empty      = (fill == '0);
    stat.full       = (fill == CNT_W'(DEPTH));
    stat.is_erase   = req_erase;
    stat.rd_valid   = rd_valid;
    stat.rd_match   = req_erase ? (rd_id == req_id) : !(rd_key < req_key);
    stat.rd_at_top  = (rd_idx == fill_top);
    stat.rd_at_pos  = (rd_idx == pos);
    stat.ra_lt_fill = (ra < fill);
    stat.ra_ge_pos  = (ra >= pos);
    stat.out_busy   = out_valid && !out_ready;
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos;
    wr_data = rdata;
    case (cmd.wr_op)
      WR_UP:   wr_addr = rd_idx + CNT_W'(1);
      WR_DOWN: wr_addr = rd_idx - CNT_W'(1);
      WR_NEW:  wr_data = {req_key, req_id};
      default: wr_en   = 1'b0;
    endcase
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rdata <= mem[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_idx <= ra;
    end
    case (cmd.ra_op)
      RA_ZERO:     ra <= '0;
      RA_TOP:      ra <= fill_top;
      RA_ABOVE_RD: ra <= rd_idx + CNT_W'(1);
      RA_INC:      ra <= ra + CNT_W'(1);
      RA_DEC:      ra <= ra - CNT_W'(1);
      default:     ra <= ra;
    endcase
    if (cmd.pos_from_rd) begin
      pos <= rd_idx;
    end else if (cmd.pos_from_fill) begin
      pos <= fill;
    end
    if (cmd.load) begin
      req_erase <= req_type;
      req_id    <= ID_BITS'(item_id);
      req_key   <= key_select ? KEY_BITS'(item_height) : KEY_BITS'(item_width);
    end
    if (cmd.status_we) begin
      status_reg <= cmd.status_code;
    end
    // track slot zero so the minimum never needs a memory read
    if (wr_en && wr_addr == '0) begin
      head_id <= wr_data[ID_BITS-1:0];
    end
    if (cmd.out_load) begin
      smallest_valid <= (fill != '0);
      smallest_id    <= (fill != '0) ? 16'(head_id) : 16'd0;
      entry_count    <= 7'(fill);
      status         <= status_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      fill       <= '0;
      key_select <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
      if (cmd.fill_inc) begin
        fill <= fill + CNT_W'(1);
      end else if (cmd.fill_dec) begin
        fill <= fill_top;
      end
      if (cfg_we) begin
        key_select <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/sorted_key_list_with_min_top.sv =====
// Sorted key list with minimum report: top level joining controller and datapath.
// A full insert or an empty erase goes straight to DONE; scan and shift touch one entry a
// cycle. A new item is accepted only in IDLE, after the previous result has been loaded;
// a waiting result holds the next in DONE.
// Reset (rst, synchronous): list empty, key_select 0, memory contents left as is.
module sorted_key_list_with_min_top import skl_pkg::*; #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16,
  parameter int ID_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] item_id,
  input  logic [15:0] item_width,
  input  logic [15:0] item_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] smallest_id,
  output logic        smallest_valid,
  output logic [6:0]  entry_count,
  output logic [1:0]  status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  skl_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_type       (req_type),
    .item_id        (item_id),
    .item_width     (item_width),
    .item_height    (item_height),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .smallest_id    (smallest_id),
    .smallest_valid (smallest_valid),
    .entry_count    (entry_count),
    .status         (status)
  );

endmodule

// ===== verif/sorted_key_list_with_min_top_tb.sv =====
// Self-checking testbench for sorted_key_list_with_min_top: a directed table, then random
// insert/erase traffic checked against an in-bench sorted-list model.
// Depends on skl_pkg (status codes) and the top level RTL.
`timescale 1ns / 1ps

module sorted_key_list_with_min_top_tb;
  import skl_pkg::*;

  localparam int DEPTH        = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_END   = 150;
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_ERASE  = 1'b1;
  localparam logic BY_WIDTH   = 1'b0;
  localparam logic BY_HEIGHT  = 1'b1;

  typedef struct packed {
    logic [15:0] min_id;
    logic        min_valid;
    logic [6:0]  count;
    status_t     stat;
  } list_report_t;

  typedef struct {
    logic        req;
    logic [15:0] id;
    logic [15:0] w;
    logic [15:0] h;
  } list_req_t;

  typedef struct {
    logic         req;
    logic [15:0]  id;
    logic [15:0]  w;
    logic [15:0]  h;
    bit           typed;
    list_report_t want;
  } dir_row_t;

  localparam list_report_t NO_REPORT = '{16'h0000, 1'b0, 7'd0, STAT_OK};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [15:0] item_id = '0;
  logic [15:0] item_width = '0;
  logic [15:0] item_height = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] smallest_id;
  logic        smallest_valid;
  logic [6:0]  entry_count;
  logic [1:0]  status;

  // model of the stored list, in key order
  logic [15:0] list_key [DEPTH];
  logic [15:0] list_id  [DEPTH];
  int          list_fill = 0;
  logic        list_by_height = BY_WIDTH;

  list_report_t report_q [$];
  logic         in_fire = 1'b0;
  bit           override_on = 1'b0;
  list_report_t override_exp = NO_REPORT;
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_asks = 0;
  int           hold_done = 0;
  int           stall_cycles = 0;

  dir_row_t dir_rows [16] = '{
    '{REQ_ERASE,  16'h1234, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b0, 7'd0, STAT_NOT_FOUND}},
    '{REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, '{16'hFFFF, 1'b1, 7'd1, STAT_OK}},
    '{REQ_INSERT, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 1'b1, 7'd2, STAT_OK}},
    '{REQ_INSERT, 16'h00A5, 16'h0000, 16'h0000, 1'b1, '{16'h00A5, 1'b1, 7'd3, STAT_OK}},
    '{REQ_INSERT, 16'h5A5A, 16'h8000, 16'h7FFF, 1'b0, NO_REPORT},
    '{REQ_INSERT, 16'hFFFF, 16'h0001, 16'hAAAA, 1'b0, NO_REPORT},
    '{REQ_ERASE,  16'hFFFF, 16'h5555, 16'hAAAA, 1'b0, NO_REPORT},
    '{REQ_ERASE,  16'hBEEF, 16'hAAAA, 16'h5555, 1'b1, '{16'h00A5, 1'b1, 7'd4, STAT_NOT_FOUND}},
    '{REQ_ERASE,  16'h00A5, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPORT},
    '{REQ_ERASE,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
    '{REQ_ERASE,  16'hFFFF, 16'h1234, 16'h4321, 1'b0, NO_REPORT},
    '{REQ_ERASE,  16'h5A5A, 16'h0F0F, 16'hF0F0, 1'b1, '{16'h0000, 1'b0, 7'd0, STAT_OK}},
    '{REQ_ERASE,  16'h5A5A, 16'hF0F0, 16'h0F0F, 1'b1, '{16'h0000, 1'b0, 7'd0, STAT_NOT_FOUND}},
    '{REQ_INSERT, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, NO_REPORT},
    '{REQ_INSERT, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, NO_REPORT},
    '{REQ_INSERT, 16'h0F0F, 16'hFFFF, 16'h0000, 1'b0, NO_REPORT}
  };

  sorted_key_list_with_min_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .item_id        (item_id),
    .item_width     (item_width),
    .item_height    (item_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smallest_id    (smallest_id),
    .smallest_valid (smallest_valid),
    .entry_count    (entry_count),
    .status         (status)
  );

  always #6 clk = ~clk;

  // Apply one request to the list model and return the report it should produce.
  function automatic list_report_t apply_request(input logic req, input logic [15:0] id,
                                                 input logic [15:0] w, input logic [15:0] h);
    list_report_t rep;
    logic [15:0]  key;
    int           pos;
    key = list_by_height ? h : w;
    rep.stat = STAT_OK;
    pos = 0;
    if (req == REQ_INSERT) begin
      if (list_fill >= DEPTH) begin
        rep.stat = STAT_FULL;
      end else begin
        // new entry goes ahead of equal keys
        while (pos < list_fill && list_key[pos] < key) pos++;
        for (int i = list_fill; i > pos; i--) begin
          list_key[i] = list_key[i - 1];
          list_id[i]  = list_id[i - 1];
        end
        list_key[pos] = key;
        list_id[pos]  = id;
        list_fill++;
      end
    end else begin
      while (pos < list_fill && list_id[pos] != id) pos++;
      if (pos >= list_fill) begin
        rep.stat = STAT_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < list_fill; i++) begin
          list_key[i] = list_key[i + 1];
          list_id[i]  = list_id[i + 1];
        end
        list_fill--;
      end
    end
    rep.min_valid = (list_fill > 0);
    rep.min_id    = (list_fill > 0) ? list_id[0] : 16'h0000;
    rep.count     = 7'(list_fill);
    return rep;
  endfunction

  // Keys lean toward ties and the ends of the range.
  function automatic logic [15:0] random_key();
    case ($urandom_range(6))
      0, 1, 2: return 16'($urandom_range(65535));
      3, 4:    return 16'($urandom_range(7));
      5:       return 16'hFFFF - 16'($urandom_range(3));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic list_req_t pick_request(input int insert_pct);
    list_req_t r;
    r.w = random_key();
    r.h = random_key();
    r.req = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_ERASE;
    if (r.req == REQ_ERASE) begin
      // mostly erase something that is stored
      if (list_fill > 0 && $urandom_range(99) < 85)
        r.id = list_id[$urandom_range(list_fill - 1)];
      else
        r.id = 16'($urandom_range(65535));
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: r.id = 16'($urandom_range(65535));
        5, 6, 7:       r.id = 16'($urandom_range(15));
        default:       r.id = (list_fill > 0) ? list_id[$urandom_range(list_fill - 1)]
                                              : 16'($urandom_range(65535));
      endcase
    end
    return r;
  endfunction

  // Sampling: prediction at input accept, comparison at output accept.
  always @(posedge clk) begin
    list_report_t want;
    list_report_t pred;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result id %h valid %b count %0d status %0d", $time,
                   smallest_id, smallest_valid, entry_count, status);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (smallest_id !== want.min_id) begin
            $display("%0t: smallest_id expected %h actual %h", $time, want.min_id, smallest_id);
            mismatches++;
          end
          if (smallest_valid !== want.min_valid) begin
            $display("%0t: smallest_valid expected %b actual %b", $time, want.min_valid,
                     smallest_valid);
            mismatches++;
          end
          if (entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count, entry_count);
            mismatches++;
          end
          if (status !== want.stat) begin
            $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = apply_request(req_type, item_id, item_width, item_height);
        report_q.insert(report_q.size(), override_on ? override_exp : pred);
      end
      if (cfg_we) list_by_height = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = hold_done + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input list_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= r.req;
    item_id     <= r.id;
    item_width  <= r.w;
    item_height <= r.h;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_key_select(input logic value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int count, input int insert_pct);
    list_req_t r;
    repeat (count) begin
      r = pick_request(insert_pct);
      send_item(r);
    end
  endtask

  initial begin
    list_req_t r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      r.req = dir_rows[i].req;
      r.id  = dir_rows[i].id;
      r.w   = dir_rows[i].w;
      r.h   = dir_rows[i].h;
      override_on  = dir_rows[i].typed;
      override_exp = dir_rows[i].want;
      send_item(r);
      override_on = 1'b0;
    end

    // switch ordering with entries still stored
    set_key_select(BY_HEIGHT);
    run_random(100, 55);

    set_key_select(BY_WIDTH);
    send_idle_pct = 53;
    run_random(120, 80);

    set_key_select(BY_HEIGHT);
    send_idle_pct  = 0;
    recv_stall_pct = 53;
    run_random(60, 25);
    hold_asks <= hold_asks + 1;
    run_random(60, 25);

    set_key_select(BY_WIDTH);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    hold_asks <= hold_asks + 1;
    run_random(110, 55);

    set_key_select(BY_HEIGHT);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(100, 85);

    wait_drained();
    repeat (SETTLE_END) @(negedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
